FILE: rtl/core/spq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the sorted priority queue.
// No dependencies; imported by spq_ctrl, the top level and the bench.
package spq_pkg;

    localparam int FUNC_W = 2;
    localparam int ID_W   = 8;
    localparam int PRI_W  = 4;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 8;

    // operation codes
    localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] OP_POP    = 2'd1;
    localparam logic [FUNC_W-1:0] OP_REMOVE = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [PRI_W-1:0] pri;
        logic [ID_W-1:0]  id;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [PRI_W-1:0]  pri;
        logic [ID_W-1:0]   id;
        logic [FUNC_W-1:0] func;
    } req_t;

    typedef struct packed {
        logic [OCC_W-1:0]  occupancy;
        logic [PRI_W-1:0]  out_pri;
        logic [ID_W-1:0]   out_id;
        logic [STAT_W-1:0] status;
    } res_t;

endpackage

FILE: rtl/core/spq_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module spq_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/spq_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the sorted priority queue: walks the entry RAM one slot per
// step with a shared index adder and key compare. Depends on spq_pkg.
module spq_ctrl #(
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  spq_pkg::req_t            req,
    output logic                     ready,
    input  logic                     out_free,
    output logic                     done,
    output spq_pkg::res_t            res,
    output logic                     ram_wr_en,
    output logic [$clog2(DEPTH)-1:0] ram_wr_addr,
    output spq_pkg::entry_t          ram_wr_data,
    output logic                     ram_rd_en,
    output logic [$clog2(DEPTH)-1:0] ram_rd_addr,
    input  spq_pkg::entry_t          ram_rd_data
);
    import spq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS_RD  = 3'd1;
    localparam logic [2:0] S_INS_CK  = 3'd2;
    localparam logic [2:0] S_SCAN_RD = 3'd3;
    localparam logic [2:0] S_SCAN_CK = 3'd4;
    localparam logic [2:0] S_SHF_RD  = 3'd5;
    localparam logic [2:0] S_SHF_WR  = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     count_reg, count_next;
    req_t              req_reg, req_next;
    logic [STAT_W-1:0] status_reg, status_next;
    entry_t            hit_reg, hit_next;

    // shared unit: index step and key compare
    logic          step_dec;
    logic [CW-1:0] step;
    logic          pri_greater;
    logic          id_match;
    entry_t        new_entry;

    assign step_dec    = (state_reg == S_INS_RD) || (state_reg == S_INS_CK);
    assign step        = step_dec ? idx_reg - 1'b1 : idx_reg + 1'b1;
    assign pri_greater = ram_rd_data.pri > req_reg.pri;
    assign id_match    = (req_reg.func == OP_POP) || (ram_rd_data.id == req_reg.id);
    assign new_entry   = '{pri: req_reg.pri, id: req_reg.id};

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        req_next    = req_reg;
        status_next = status_reg;
        hit_next    = hit_reg;
        ram_wr_en   = 1'b0;
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = step[AW-1:0];
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    req_next    = req;
                    status_next = ST_OK;
                    hit_next    = '0;
                    idx_next    = '0;
                    case (req.func)
                        OP_INSERT: begin
                            if (count_reg == FULL_COUNT) begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end else begin
                                idx_next   = count_reg;
                                state_next = S_INS_RD;
                            end
                        end
                        OP_POP: begin
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        OP_REMOVE: begin
                            state_next = S_SCAN_RD;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                if (idx_reg == '0) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_data = new_entry;
                    count_next  = count_reg + 1'b1;
                    state_next  = S_DONE;
                end else begin
                    ram_rd_en  = 1'b1;
                    state_next = S_INS_CK;
                end
            end
            S_INS_CK: begin
                // move strictly greater priorities up one slot
                ram_wr_en = 1'b1;
                if (pri_greater) begin
                    idx_next   = step;
                    state_next = S_INS_RD;
                end else begin
                    ram_wr_data = new_entry;
                    count_next  = count_reg + 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_SCAN_RD: begin
                if (idx_reg == count_reg) begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_DONE;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_reg[AW-1:0];
                    state_next  = S_SCAN_CK;
                end
            end
            S_SCAN_CK: begin
                if (id_match) begin
                    hit_next   = ram_rd_data;
                    state_next = S_SHF_RD;
                end else begin
                    idx_next   = step;
                    state_next = S_SCAN_RD;
                end
            end
            S_SHF_RD: begin
                // close the gap left at idx
                if (step >= count_reg) begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end else begin
                    ram_rd_en  = 1'b1;
                    state_next = S_SHF_WR;
                end
            end
            S_SHF_WR: begin
                ram_wr_en  = 1'b1;
                idx_next   = step;
                state_next = S_SHF_RD;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign ram_wr_addr = idx_reg[AW-1:0];
    assign ready       = (state_reg == S_IDLE);
    assign done        = (state_reg == S_DONE) && out_free;
    assign res         = '{occupancy: OCC_W'(count_reg), out_pri: hit_reg.pri,
                           out_id: hit_reg.id, status: status_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        idx_reg    <= idx_next;
        req_reg    <= req_next;
        status_reg <= status_next;
        hit_reg    <= hit_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT)
        else $error("entry count beyond depth");

    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> (state_reg == S_INS_RD || state_reg == S_INS_CK ||
                       state_reg == S_SHF_WR))
        else $error("RAM write outside a write step");

    a_check_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN_CK || state_reg == S_INS_CK || state_reg == S_SHF_WR)
        |-> $past(ram_rd_en))
        else $error("compare step without a preceding RAM read");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |=> (state_reg == S_DONE || state_reg == S_IDLE))
        else $error("count changed away from the end of a request");

endmodule

FILE: rtl/core/sorted_priority_queue_top.sv
`timescale 1ns / 1ps
// Top level of the sorted priority queue: stream ports, result register,
// sequencer and entry RAM. Depends on spq_pkg, spq_ctrl and spq_ram.
//
// Bounded priority queue of DEPTH entries (id, priority), kept in ascending
// priority order with ties in arrival order, in a single RAM with one write
// and one registered read port. One request at a time: insert, pop head or
// remove by id. The time from an accepted request until s_tready rises again
// depends on the walk: insert moves each entry of greater priority up one
// slot, pop closes the gap behind the head by moving every later entry down,
// and remove scans from the head for the id and then closes the gap in the
// same way, or scans every stored entry when it is not found. Insert on full,
// pop on empty and the unused code go straight to the result. The result is
// valid on m_tvalid in the cycle s_tready rises; s_tready is low while a
// request is in work, and a finished result waits until the output register
// is free.
module sorted_priority_queue_top #(
    parameter int DEPTH = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [7:0] req_id, [11:8] req_priority, [15:12] zero
    input  logic [1:0]  s_tuser,  // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // [7:0] out_id, [11:8] out_priority, [19:12] occupancy
    output logic [1:0]  m_tuser   // [1:0] status
);
    import spq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic   start;
    logic   ready;
    logic   done;
    logic   out_free;
    req_t   req;
    res_t   res;

    logic            ram_wr_en;
    logic [AW-1:0]   ram_wr_addr;
    entry_t          ram_wr_data;
    logic            ram_rd_en;
    logic [AW-1:0]   ram_rd_addr;
    entry_t          ram_rd_data;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [23:0] m_tdata_reg, m_tdata_next;
    logic [1:0]  m_tuser_reg, m_tuser_next;

    assign s_tready = ready;
    assign start    = s_tvalid && ready;
    assign req      = '{pri: s_tdata[11:8], id: s_tdata[7:0], func: s_tuser};
    assign out_free = !m_tvalid_reg || m_tready;

    spq_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (start),
        .req         (req),
        .ready       (ready),
        .out_free    (out_free),
        .done        (done),
        .res         (res),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    spq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (done) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {4'd0, res.occupancy, res.out_pri, res.out_id};
            m_tuser_next  = res.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for sorted_priority_queue_top: directed and random requests,
// each checked against a behavioural copy of the sorted store.
// Depends on spq_pkg and the RTL of the block.
module tb_top;
    import spq_pkg::*;

    localparam int Q_DEPTH    = 128;
    localparam int CYCLE_CAP  = 1_000_000;
    localparam int TAIL_WAIT  = 300;

    // operation code with no function; the block answers ok and changes nothing
    localparam logic [FUNC_W-1:0] OP_UNUSED = 2'd3;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;  // [7:0] req_id, [11:8] req_priority, [15:12] zero
    logic [1:0]  s_tuser  = '0;  // [1:0] func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // [7:0] out_id, [11:8] out_priority, [19:12] occupancy
    logic [1:0]  m_tuser;        // [1:0] status

    entry_t held_entries[$];     // mirror of the store, head first
    res_t   outcome_fifo[$];     // results still owed by the block
    int     err_cnt   = 0;
    int     cyc       = 0;
    int     burst_left = 0;
    int     rdy_mode  = 0;

    sorted_priority_queue_top #(.DEPTH(Q_DEPTH)) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one request to the mirror and return the result it should give.
    function automatic res_t apply_queue_op(input logic [FUNC_W-1:0] func,
                                            input logic [ID_W-1:0] id,
                                            input logic [PRI_W-1:0] pri);
        res_t   r;
        entry_t fresh;
        int     pos;
        r = '0;
        case (func)
            OP_INSERT: begin
                if (held_entries.size() >= Q_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // goes behind every entry of equal or lower priority
                    pos = held_entries.size();
                    while (pos > 0 && held_entries[pos-1].pri > pri) pos--;
                    fresh.id  = id;
                    fresh.pri = pri;
                    held_entries.insert(pos, fresh);
                end
            end
            OP_POP: begin
                if (held_entries.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.out_id  = held_entries[0].id;
                    r.out_pri = held_entries[0].pri;
                    void'(held_entries.pop_front());
                end
            end
            OP_REMOVE: begin
                pos = -1;
                foreach (held_entries[k])
                    if (pos < 0 && held_entries[k].id == id) pos = k;
                if (pos < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    r.out_id  = held_entries[pos].id;
                    r.out_pri = held_entries[pos].pri;
                    held_entries.delete(pos);
                end
            end
            default: ;
        endcase
        r.occupancy = OCC_W'(held_entries.size());
        return r;
    endfunction

    // Offer one request; bursts of random length separated by random gaps.
    task automatic push_request(input logic [FUNC_W-1:0] func,
                                input logic [ID_W-1:0] id,
                                input logic [PRI_W-1:0] pri);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {4'h0, pri, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        outcome_fifo.push_back(apply_queue_op(func, id, pri));
    endtask

    // Hold off the sender until every owed result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (outcome_fifo.size() != 0) @(posedge aclk);
    endtask

    task automatic test_empty_cases();
        push_request(OP_POP, 8'h00, 4'h0);
        push_request(OP_REMOVE, 8'h00, 4'h0);
        push_request(OP_UNUSED, 8'hFF, 4'hF);
    endtask

    task automatic test_ordering();
        push_request(OP_INSERT, 8'h10, 4'h7);
        push_request(OP_INSERT, 8'hFF, 4'hF);
        push_request(OP_INSERT, 8'h00, 4'h0);
        push_request(OP_INSERT, 8'h20, 4'h7);   // tie: behind 0x10
        push_request(OP_INSERT, 8'h30, 4'h7);
        push_request(OP_UNUSED, 8'hAA, 4'h5);
        push_request(OP_REMOVE, 8'h20, 4'hF);   // middle of the tie run
        push_request(OP_REMOVE, 8'h55, 4'h0);   // no such id
        push_request(OP_INSERT, 8'h10, 4'h2);   // duplicate id, nearer the head
        push_request(OP_REMOVE, 8'h10, 4'h0);   // takes the first from the head
        push_request(OP_REMOVE, 8'hFF, 4'h0);   // tail entry
        push_request(OP_POP, 8'h00, 4'h0);
        push_request(OP_POP, 8'h00, 4'h0);
        push_request(OP_POP, 8'h00, 4'h0);
        push_request(OP_POP, 8'h00, 4'h0);
        push_request(OP_POP, 8'h00, 4'h0);
    endtask

    task automatic test_full();
        entry_t victim;
        repeat (Q_DEPTH)
            push_request(OP_INSERT, ID_W'($urandom_range(255)), PRI_W'($urandom_range(15)));
        push_request(OP_INSERT, 8'h5A, 4'h0);   // dropped, store full
        push_request(OP_UNUSED, 8'h00, 4'h0);
        victim = held_entries[held_entries.size() - 1];
        push_request(OP_REMOVE, victim.id, 4'h0);
        push_request(OP_INSERT, 8'hA5, 4'hF);
        push_request(OP_INSERT, 8'h3C, 4'h8);   // dropped again
        repeat (Q_DEPTH + 1) push_request(OP_POP, 8'h00, 4'h0);
    endtask

    // Random mix; removes mostly aim at ids that are actually held.
    task automatic test_random_mix(input int n, input int ins_pct, input int pop_pct);
        int              roll;
        logic [ID_W-1:0] id;
        repeat (n) begin
            roll = $urandom_range(99);
            if (roll < ins_pct) begin
                id = ($urandom_range(1) == 0) ? ID_W'($urandom_range(15))
                                              : ID_W'($urandom_range(255));
                push_request(OP_INSERT, id, PRI_W'($urandom_range(15)));
            end else if (roll < ins_pct + pop_pct) begin
                push_request(OP_POP, ID_W'($urandom_range(255)), PRI_W'($urandom_range(15)));
            end else if (roll < 96) begin
                if (held_entries.size() != 0 && $urandom_range(3) != 0)
                    id = held_entries[$urandom_range(held_entries.size() - 1)].id;
                else
                    id = ID_W'($urandom_range(255));
                push_request(OP_REMOVE, id, PRI_W'($urandom_range(15)));
            end else begin
                push_request(OP_UNUSED, ID_W'($urandom_range(255)),
                             PRI_W'($urandom_range(15)));
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_cases();
        test_ordering();
        wait_drained();
        test_full();
        wait_drained();
        test_random_mix(60, 45, 25);
        wait_drained();
        test_random_mix(70, 75, 10);
        test_random_mix(40, 20, 50);
        wait_drained();
        repeat (TAIL_WAIT) @(posedge aclk);
        if (err_cnt == 0 && outcome_fifo.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // Receiver: the ready pattern is always ready, random or periodic; the mode is re-drawn at random as cyc advances.
    always @(posedge aclk) begin
        if (cyc % 128 == 0) rdy_mode = $urandom_range(2);
        case (rdy_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(3) != 0);
            default: m_tready <= (cyc % 5) != 4;
        endcase
    end

    always @(posedge aclk) begin : result_check
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (outcome_fifo.size() == 0) begin
                $error("result with no request outstanding");
                err_cnt++;
            end else begin
                want = outcome_fifo.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    err_cnt++;
                end
                if (m_tdata[7:0] !== want.out_id) begin
                    $error("out_id: expected %0d, got %0d", want.out_id, m_tdata[7:0]);
                    err_cnt++;
                end
                if (m_tdata[11:8] !== want.out_pri) begin
                    $error("out_priority: expected %0d, got %0d", want.out_pri, m_tdata[11:8]);
                    err_cnt++;
                end
                if (m_tdata[19:12] !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy, m_tdata[19:12]);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_CAP) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

endmodule

FILE: files.f
rtl/core/spq_pkg.sv
rtl/core/spq_ram.sv
rtl/core/spq_ctrl.sv
rtl/core/sorted_priority_queue_top.sv
bench/tb_top.sv
